// ===== hw/rtl/median_of_sample_block_unit_macros.svh =====
// assertion macros for the median block rtl
`ifndef MEDIAN_OF_SAMPLE_BLOCK_UNIT_MACROS_SVH
`define MEDIAN_OF_SAMPLE_BLOCK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define MEDBLK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("medblk assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define MEDBLK_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("medblk assertion failed");
`else
`define MEDBLK_ASSERT_IMP(label, ante, cons)
`define MEDBLK_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/medblk_pkg.sv =====
// shared types and constants for the median block
`default_nettype none

package medblk_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 6;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the current sample in order
    logic shift;  // move every value one cell toward cell 0
  } cell_ctl_t;

  typedef enum logic [0:0] {
    ST_FILL,
    ST_SEEK
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/medblk_cell.sv =====
// one cell of the ordered sample chain
`default_nettype none

module medblk_cell (
  input  wire                                clk,
  input  wire  medblk_pkg::cell_ctl_t        ctl,
  input  wire  [medblk_pkg::SAMPLE_W-1:0]    sample,
  input  wire                                occ,
  input  wire  [medblk_pkg::SAMPLE_W-1:0]    left_val,
  input  wire                                left_gt,
  input  wire  [medblk_pkg::SAMPLE_W-1:0]    right_val,
  output logic                               gt,
  output logic [medblk_pkg::SAMPLE_W-1:0]    val
);

  logic [medblk_pkg::SAMPLE_W-1:0] val_r;
  logic [medblk_pkg::SAMPLE_W-1:0] val_nxt;

  // an empty cell counts as larger than any sample
  assign gt  = !occ || (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && gt) begin
      val_nxt = left_gt ? left_val : sample;
    end else if (ctl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/median_of_sample_block_unit.sv =====
// top level of the block median filter: cell chain, sequencer and result register
`default_nettype none

`include "median_of_sample_block_unit_macros.svh"

// Block median filter. Samples come in one beat at a time on start/busy;
// in_last_sample marks the final sample of a block. Every kept sample is
// inserted in ascending order into a chain of MAX_SAMPLES cells in the same
// cycle that it is taken, so busy stays low for a sample without the end flag.
// Once MAX_SAMPLES samples are kept, further samples of the block are dropped
// and the result reports overflow. On the sample that ends a block, busy goes
// high while the chain shifts toward cell 0 once a cycle, n being the kept
// count, until the middle element (or the two middle elements) sit in cells 0
// and 1; then the median is formed in the last busy cycle (odd n: middle value;
// even n: floor of the 17-bit sum of the middle pair over two). The result
// beat is registered from that cycle and appears on the out_ ports for exactly
// one cycle with out_valid, and busy is low again in that
// same cycle. The receiver cannot stall: out_valid is a strobe, and the next
// block may start while the result of the previous one is on the ports.
// out_sample_count is the kept count in six bits.
module median_of_sample_block_unit #(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [medblk_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire                                in_last_sample,
  output logic                               out_valid,
  output logic [medblk_pkg::SAMPLE_W-1:0]    out_median,
  output logic [medblk_pkg::COUNT_W-1:0]     out_sample_count,
  output logic                               out_overflow
);

  // count width must hold MAX_SAMPLES itself
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  medblk_pkg::state_t    state_r, state_nxt;
  medblk_pkg::cell_ctl_t ctl;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;      // shifts left before the median is in place
  logic          drop_r, drop_nxt;
  logic          finish;              // median is in cells 0/1 this cycle
  logic          accept;
  logic          full;
  logic [CW-1:0] n_after;             // kept count including this beat

  logic                             out_valid_r, out_valid_nxt;
  logic [medblk_pkg::SAMPLE_W-1:0]  out_median_r, out_median_nxt;
  logic [medblk_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                             out_ovf_r, out_ovf_nxt;

  // chain wiring
  logic [medblk_pkg::SAMPLE_W-1:0] cell_val [MAX_SAMPLES];
  logic                            cell_gt  [MAX_SAMPLES];
  logic                            cell_occ [MAX_SAMPLES];
  logic [medblk_pkg::SAMPLE_W-1:0] pair_hi;
  logic [medblk_pkg::SAMPLE_W:0]   pair_sum;

  assign full    = (count_r == CW'(MAX_SAMPLES));
  assign accept  = start && !busy;
  assign n_after = full ? count_r : (count_r + CW'(1));

  // ---------------------------------------------------------------------------
  // cell chain: cell 0 holds the smallest kept sample
  // ---------------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
      logic [medblk_pkg::SAMPLE_W-1:0] lv;
      logic                            lg;
      logic [medblk_pkg::SAMPLE_W-1:0] rv;

      // cell is holding a kept sample
      assign cell_occ[gi] = (CW'(gi) < count_r);

      if (gi == 0) begin : g_head
        assign lv = '0;
        assign lg = 1'b0;
      end else begin : g_body
        assign lv = cell_val[gi-1];
        assign lg = cell_gt[gi-1];
      end

      if (gi == MAX_SAMPLES - 1) begin : g_tail
        assign rv = cell_val[gi];
      end else begin : g_inner
        assign rv = cell_val[gi+1];
      end

      medblk_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .sample    (in_sample),
        .occ       (cell_occ[gi]),
        .left_val  (lv),
        .left_gt   (lg),
        .right_val (rv),
        .gt        (cell_gt[gi]),
        .val       (cell_val[gi])
      );
    end

    // upper middle element for an even count; a one-cell chain never has one
    if (MAX_SAMPLES > 1) begin : g_pair
      assign pair_hi = cell_val[1];
    end else begin : g_single
      assign pair_hi = cell_val[0];
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      medblk_pkg::ST_FILL: begin
        if (accept && in_last_sample) begin
          state_nxt = medblk_pkg::ST_SEEK;
        end
      end
      medblk_pkg::ST_SEEK: begin
        if (rem_r == '0) begin
          state_nxt = medblk_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = medblk_pkg::ST_FILL;
      end
    endcase
  end

  always_comb begin
    ctl    = '0;
    busy   = 1'b0;
    finish = 1'b0;
    case (state_r)
      medblk_pkg::ST_FILL: begin
        // dropped beats still count as taken, they just leave the chain alone
        ctl.ins = start && !full;
      end
      medblk_pkg::ST_SEEK: begin
        busy      = 1'b1;
        ctl.shift = (rem_r != '0);
        finish    = (rem_r == '0);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // block bookkeeping
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    rem_nxt   = rem_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end
    if (accept && full) begin
      drop_nxt = 1'b1;
    end
    if (accept && in_last_sample) begin
      // (n-1)/2 shifts put the middle, or the lower of the middle pair, in cell 0
      rem_nxt = (n_after - CW'(1)) >> 1;
    end else if (ctl.shift) begin
      rem_nxt = rem_r - CW'(1);
    end
    if (finish) begin
      count_nxt = '0;
      drop_nxt  = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  assign pair_sum = {1'b0, cell_val[0]} + {1'b0, pair_hi};

  always_comb begin
    out_valid_nxt  = finish;
    out_median_nxt = out_median_r;
    out_count_nxt  = out_count_r;
    out_ovf_nxt    = out_ovf_r;
    if (finish) begin
      out_median_nxt = count_r[0] ? cell_val[0] : pair_sum[medblk_pkg::SAMPLE_W:1];
      out_count_nxt  = medblk_pkg::COUNT_W'(count_r);
      out_ovf_nxt    = drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= medblk_pkg::ST_FILL;
      count_r     <= '0;
      drop_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_median_r <= out_median_nxt;
    out_count_r  <= out_count_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median       = out_median_r;
  assign out_sample_count = out_count_r;
  assign out_overflow     = out_ovf_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `MEDBLK_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(MAX_SAMPLES))
  `MEDBLK_ASSERT_NXT(a_last_goes_busy, start && !busy && in_last_sample, busy)
  `MEDBLK_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  `MEDBLK_ASSERT_IMP(a_no_result_while_busy, busy, !out_valid)
  `MEDBLK_ASSERT_IMP(a_cleared_on_result, out_valid, count_r == '0 || start)

endmodule

`default_nettype wire

// ===== bench/median_block_checker.sv =====
// checker for the block median filter: sorted-store predictor and result compare
`timescale 1ns / 1ps

module median_block_checker
  import medblk_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 busy,
  input  wire  [SAMPLE_W-1:0] in_sample,
  input  wire                 in_last_sample,
  input  wire                 out_valid,
  input  wire  [SAMPLE_W-1:0] out_median,
  input  wire  [COUNT_W-1:0]  out_sample_count,
  input  wire                 out_overflow,
  output int                  fail_count,
  output int                  medians_pending
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]  count;
    logic                overflow;
  } block_result_t;

  logic [SAMPLE_W-1:0] ordered_samples [MAX_SAMPLES];
  int unsigned         kept_samples;
  logic                samples_dropped;
  block_result_t       expected_medians [$];

  initial begin
    fail_count      = 0;
    medians_pending = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // insertion into the ascending store, or drop once full
  task automatic keep_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned pos;
    if (kept_samples < MAX_SAMPLES) begin
      pos = kept_samples;
      while (pos > 0 && ordered_samples[pos-1] > value) begin
        ordered_samples[pos] = ordered_samples[pos-1];
        pos--;
      end
      ordered_samples[pos] = value;
      kept_samples++;
    end else begin
      samples_dropped = 1'b1;
    end
  endtask

  function automatic block_result_t block_median();
    block_result_t       res;
    logic [SAMPLE_W:0]   pair_sum;
    int unsigned         mid;
    mid = kept_samples / 2;
    if (kept_samples % 2 == 1) begin
      res.median = ordered_samples[mid];
    end else begin
      pair_sum   = {1'b0, ordered_samples[mid-1]} + {1'b0, ordered_samples[mid]};
      res.median = pair_sum[SAMPLE_W:1];
    end
    res.count    = kept_samples[COUNT_W-1:0];
    res.overflow = samples_dropped;
    return res;
  endfunction

  always @(posedge clk) begin
    block_result_t want;
    if (!rst_n) begin
      kept_samples    = 0;
      samples_dropped = 1'b0;
      expected_medians.delete();
    end else begin
      // a result beat may land on the same edge as the next block's first sample
      if (out_valid) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("result beat with nothing expected, median", out_median, 0);
        end else begin
          want = expected_medians.pop_front();
          if (out_median !== want.median)
            report_mismatch("median", out_median, want.median);
          if (out_sample_count !== want.count)
            report_mismatch("sample_count", out_sample_count, want.count);
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", out_overflow, want.overflow);
        end
      end
      if (start && !busy) begin
        keep_sample(in_sample);
        if (in_last_sample) begin
          expected_medians.push_back(block_median());
          kept_samples    = 0;
          samples_dropped = 1'b0;
        end
      end
    end
    medians_pending = expected_medians.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the block median filter: clock, reset, sample blocks, verdict
`timescale 1ns / 1ps

module tb_top;
  import medblk_pkg::*;

  localparam int unsigned MAX_SAMPLES = 32;
  localparam int unsigned ITEM_GOAL   = 800;

  // value styles for the samples of one block
  typedef enum int {
    VAL_ANY,
    VAL_DUPES,
    VAL_EXTREMES,
    VAL_NEAR_TOP
  } value_style_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_last_sample;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_median;
  logic [COUNT_W-1:0]  out_sample_count;
  logic                out_overflow;
  int                  fail_count;
  int                  medians_pending;
  int unsigned         samples_sent;
  bit                  no_gaps;

  median_of_sample_block_unit #(.MAX_SAMPLES(MAX_SAMPLES)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample       (in_sample),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_median      (out_median),
    .out_sample_count(out_sample_count),
    .out_overflow    (out_overflow)
  );

  median_block_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample       (in_sample),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_median      (out_median),
    .out_sample_count(out_sample_count),
    .out_overflow    (out_overflow),
    .fail_count      (fail_count),
    .medians_pending (medians_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // idle gap after a beat: mostly none, some short, a few long;
  // blocks flagged no_gaps run back to back
  task automatic idle_gap();
    int unsigned roll;
    int unsigned cycles;
    roll   = $urandom_range(0, 99);
    cycles = 0;
    if (!no_gaps) begin
      if (roll >= 92) cycles = $urandom_range(6, 25);
      else if (roll >= 65) cycles = $urandom_range(1, 3);
    end
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // present one sample beat and hold it until taken (busy low at the edge)
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
    start          <= 1'b1;
    in_sample      <= value;
    in_last_sample <= last;
    do @(posedge clk); while (busy);
    samples_sent++;
    idle_gap();
  endtask

  task automatic send_values(input logic [SAMPLE_W-1:0] vals [$]);
    foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input value_style_t style);
    logic [SAMPLE_W-1:0] v;
    case (style)
      VAL_DUPES:    v = SAMPLE_W'($urandom_range(0, 7));
      VAL_EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h0000;
          1:       v = 16'hFFFF;
          2:       v = 16'h7FFF;
          default: v = 16'h8000;
        endcase
      end
      VAL_NEAR_TOP: v = SAMPLE_W'($urandom_range(65500, 65535));
      default:      v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random_block(input int unsigned len);
    value_style_t style;
    int unsigned  roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) style = VAL_ANY;
    else if (roll < 75) style = VAL_DUPES;
    else if (roll < 88) style = VAL_EXTREMES;
    else style = VAL_NEAR_TOP;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) send_sample(pick_sample(style), i == len - 1);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] blk [$];
    int unsigned         len;
    int unsigned         roll;
    int unsigned         settle;

    start          <= 1'b0;
    in_sample      <= '0;
    in_last_sample <= 1'b0;
    rst_n          <= 1'b0;
    samples_sent   = 0;
    no_gaps        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-sample blocks at both ends of the range
    blk = '{16'h0000};
    send_values(blk);
    blk = '{16'hFFFF};
    send_values(blk);
    // even count where the middle pair needs the 17th sum bit
    blk = '{16'hFFFF, 16'hFFFF};
    send_values(blk);
    blk = '{16'h0000, 16'hFFFF};
    send_values(blk);
    // out-of-order arrivals force a shift on insert
    blk = '{16'd5, 16'd3, 16'd9};
    send_values(blk);
    // equal samples kept side by side
    blk = '{16'd7, 16'd7, 16'd7, 16'd7};
    send_values(blk);
    blk = '{16'hFFFF, 16'h0000, 16'hFFFE, 16'h0001, 16'h8000};
    send_values(blk);
    blk = '{16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC};
    send_values(blk);

    // random: a block that just fills the store, two that overflow with the
    // end flag on a dropped beat, then mostly short blocks
    send_random_block(MAX_SAMPLES);
    send_random_block(MAX_SAMPLES + 1);
    send_random_block(MAX_SAMPLES + 7);
    while (samples_sent < ITEM_GOAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) len = $urandom_range(1, 8);
      else if (roll < 90) len = $urandom_range(9, MAX_SAMPLES - 1);
      else len = $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 8);
      send_random_block(len);
    end

    // drain: wait for every expected median, then cover the longest latency
    start <= 1'b0;
    while (medians_pending != 0) @(posedge clk);
    settle = (MAX_SAMPLES - 1) / 2 + 4;
    repeat (settle) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
